/* rtl/magnetometer_iron_correction_core_macros.svh */
// Assertion macros used by the checker file of the magnetometer correction core.
`ifndef MAGNETOMETER_IRON_CORRECTION_CORE_MACROS_SVH
`define MAGNETOMETER_IRON_CORRECTION_CORE_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define MIC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("magnetometer correction core: assertion failed");

// Expression that must never be true at a clock edge.
`define MIC_ASSERT_NEVER(lbl, clk, rstn, expr) \
  `MIC_ASSERT(lbl, clk, rstn, !(expr))

`endif

/* rtl/mic_pkg.sv */
// Shared types and constants of the magnetometer correction core.
package mic_pkg;

  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned DIFF_W     = AXIS_W + 1;
  localparam int unsigned PROD_W     = DIFF_W + AXIS_W;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 3 * AXIS_W;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Element 0 is x, in the lowest bits.
  typedef axis_t [2:0]      vec_t;
  typedef diff_t [2:0]      dvec_t;
  // [input axis][output axis]
  typedef axis_t [2:0][2:0] coef_mat_t;
  typedef prod_t [2:0][2:0] prod_mat_t;

  localparam axis_t AXIS_MAX = 16'sh7FFF;
  localparam axis_t AXIS_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_MODE     = 3'd0,
    CFG_INVERT_Z     = 3'd1,
    CFG_OFFSET_XYZ   = 3'd2,
    CFG_SCALE_XYZ    = 3'd3,
    CFG_MATRIX_ROW_X = 3'd4,
    CFG_MATRIX_ROW_Y = 3'd5,
    CFG_MATRIX_ROW_Z = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_PASS     = 2'd0,
    MODE_SCALE    = 2'd1,
    MODE_MATRIX   = 2'd2,
    MODE_PASS_ALT = 2'd3
  } mode_e;

  // Sample after hold selection and offset removal.
  typedef struct packed {
    vec_t  v;
    dvec_t d;
    logic  ok;
    logic  clip;
  } front_t;

  typedef struct packed {
    vec_t cal;
    logic used_held;
    logic saturated;
  } res_t;

endpackage

/* rtl/mic_if.sv */
// Handshake interfaces of the magnetometer correction core: sample, result and config.
interface mic_in_if;
  logic                valid;
  logic                ready;
  mic_pkg::axis_t      raw_x;
  mic_pkg::axis_t      raw_y;
  mic_pkg::axis_t      raw_z;
  logic                sample_ok;

  modport source (output valid, output raw_x, output raw_y, output raw_z,
                  output sample_ok, input ready);
  modport sink   (input valid, input raw_x, input raw_y, input raw_z,
                  input sample_ok, output ready);
endinterface

interface mic_out_if;
  logic                valid;
  logic                ready;
  mic_pkg::axis_t      cal_x;
  mic_pkg::axis_t      cal_y;
  mic_pkg::axis_t      cal_z;
  logic                used_held;
  logic                saturated;

  modport source (output valid, output cal_x, output cal_y, output cal_z,
                  output used_held, output saturated, input ready);
  modport sink   (input valid, input cal_x, input cal_y, input cal_z,
                  input used_held, input saturated, output ready);
endinterface

interface mic_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mic_pkg::CFG_IDX_W-1:0]     index;
  logic [mic_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/magnetometer_iron_correction_core.sv */
// Top level of the magnetometer hard/soft-iron correction core.
//
// Takes one raw three-axis sample per beat and returns one corrected sample per beat.
// A good sample (sample_ok set) optionally has z negated, is held, and is corrected; a
// failed one is replaced by the held sample and flagged with used_held. cal_mode selects
// pass-through, offset plus per-axis scale, or offset plus a 3x3 soft-iron matrix with
// signed coefficients of COEF_FRAC_BITS fraction bits; results are floored, saturated to
// 16 bits and clipping is flagged. Throughput is one sample per clock while results are
// taken. The result passes through the input register, the register behind the nine
// 17x16 multipliers and the result register. The input stays ready while a result waits,
// until all three stages are full. Write configuration only when idle.
module magnetometer_iron_correction_core #(
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mic_cfg_if.sink     cfg_i,
  mic_in_if.sink      sample_i,
  mic_out_if.source   result_o
);

  localparam mic_pkg::axis_t COEF_ONE  = mic_pkg::axis_t'(1) << COEF_FRAC_BITS;
  localparam mic_pkg::axis_t COEF_ZERO = '0;
  localparam mic_pkg::vec_t  ROW_X     = {COEF_ZERO, COEF_ZERO, COEF_ONE};
  localparam mic_pkg::vec_t  ROW_Y     = {COEF_ZERO, COEF_ONE, COEF_ZERO};
  localparam mic_pkg::vec_t  ROW_Z     = {COEF_ONE, COEF_ZERO, COEF_ZERO};

  mic_pkg::mode_e      mode_q;
  logic                invert_z_q;
  mic_pkg::vec_t       offset_q;
  mic_pkg::vec_t       scale_q;
  mic_pkg::coef_mat_t  matrix_q;
  mic_pkg::vec_t       held_q;

  mic_pkg::front_t     front_d, s1_q;
  logic                s1_valid_q;
  logic                s1_ready;
  logic                mac_ready;
  logic                in_fire;
  mic_pkg::coef_mat_t  coef;
  logic                pass;
  mic_pkg::res_t       res;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= mic_pkg::MODE_PASS;
      invert_z_q <= 1'b0;
      offset_q   <= '0;
      scale_q    <= {COEF_ONE, COEF_ONE, COEF_ONE};
      matrix_q   <= {ROW_Z, ROW_Y, ROW_X};
    end else if (cfg_i.valid) begin
      case (mic_pkg::cfg_idx_e'(cfg_i.index))
        mic_pkg::CFG_CAL_MODE:     mode_q      <= mic_pkg::mode_e'(cfg_i.data[1:0]);
        mic_pkg::CFG_INVERT_Z:     invert_z_q  <= cfg_i.data[0];
        mic_pkg::CFG_OFFSET_XYZ:   offset_q    <= cfg_i.data;
        mic_pkg::CFG_SCALE_XYZ:    scale_q     <= cfg_i.data;
        mic_pkg::CFG_MATRIX_ROW_X: matrix_q[0] <= cfg_i.data;
        mic_pkg::CFG_MATRIX_ROW_Y: matrix_q[1] <= cfg_i.data;
        mic_pkg::CFG_MATRIX_ROW_Z: matrix_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // hold selection, z negation and offset removal
  always_comb begin
    mic_pkg::axis_t z_adj;
    logic           z_clip;
    z_adj  = sample_i.raw_z;
    z_clip = 1'b0;
    if (invert_z_q) begin
      if (sample_i.raw_z == mic_pkg::AXIS_MIN) begin
        z_adj  = mic_pkg::AXIS_MAX;
        z_clip = 1'b1;
      end else begin
        z_adj = -sample_i.raw_z;
      end
    end
    if (sample_i.sample_ok) begin
      front_d.v    = {z_adj, sample_i.raw_y, sample_i.raw_x};
      front_d.clip = z_clip;
    end else begin
      front_d.v    = held_q;
      front_d.clip = 1'b0;
    end
    front_d.ok = sample_i.sample_ok;
    for (int i = 0; i < 3; i++) begin
      front_d.d[i] = mic_pkg::diff_t'(front_d.v[i]) - mic_pkg::diff_t'(offset_q[i]);
    end
  end

  assign s1_ready       = !s1_valid_q || mac_ready;
  assign sample_i.ready = s1_ready;
  assign in_fire        = sample_i.valid && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_fire && sample_i.sample_ok) begin
        held_q <= front_d.v;
      end
      if (s1_ready) begin
        s1_valid_q <= sample_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= front_d;
    end
  end

  // mode 1 runs through the matrix path with the scales on the diagonal
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        if (mode_q == mic_pkg::MODE_SCALE) begin
          coef[j][i] = (i == j) ? scale_q[i] : COEF_ZERO;
        end else begin
          coef[j][i] = matrix_q[j][i];
        end
      end
    end
  end

  assign pass = (mode_q != mic_pkg::MODE_SCALE) && (mode_q != mic_pkg::MODE_MATRIX);

  mic_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (mac_ready),
    .front_i     (s1_q),
    .coef_i      (coef),
    .pass_i      (pass),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .res_o       (res)
  );

  assign result_o.cal_x     = res.cal[0];
  assign result_o.cal_y     = res.cal[1];
  assign result_o.cal_z     = res.cal[2];
  assign result_o.used_held = res.used_held;
  assign result_o.saturated = res.saturated;

endmodule

/* rtl/mic_mac.sv */
// Product stage and sum, floor-shift and saturate stage of the correction datapath.
module mic_mac #(
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mic_pkg::front_t    front_i,
  input  mic_pkg::coef_mat_t coef_i,
  input  logic               pass_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mic_pkg::res_t      res_o
);

  localparam int unsigned SH_W = mic_pkg::SUM_W - COEF_FRAC_BITS;
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(mic_pkg::AXIS_MAX);
  localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(mic_pkg::AXIS_MIN);

  // product stage
  logic                  p_valid_q;
  logic                  p_ready;
  mic_pkg::prod_mat_t    prod_d, prod_q;
  mic_pkg::vec_t         p_v_q;
  logic                  p_ok_q, p_clip_q, p_pass_q;

  // result stage
  logic                  r_valid_q;
  logic                  r_ready;
  mic_pkg::res_t         res_d, res_q;

  assign r_ready    = !r_valid_q || out_ready_i;
  assign p_ready    = !p_valid_q || r_ready;
  assign in_ready_o = p_ready;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        prod_d[j][i] = mic_pkg::prod_t'(front_i.d[j]) * mic_pkg::prod_t'(coef_i[j][i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (p_ready) begin
      p_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_ready && in_valid_i) begin
      prod_q   <= prod_d;
      p_v_q    <= front_i.v;
      p_ok_q   <= front_i.ok;
      p_clip_q <= front_i.clip;
      p_pass_q <= pass_i;
    end
  end

  always_comb begin
    mic_pkg::sum_t             sum;
    logic signed [SH_W-1:0]    sh;
    logic                      clip;
    clip = p_clip_q;
    res_d.cal = p_v_q;
    for (int i = 0; i < 3; i++) begin
      sum = mic_pkg::sum_t'(prod_q[0][i]) + mic_pkg::sum_t'(prod_q[1][i])
          + mic_pkg::sum_t'(prod_q[2][i]);
      // drop fraction bits: arithmetic shift rounds toward minus infinity
      sh  = $signed(sum[mic_pkg::SUM_W-1:COEF_FRAC_BITS]);
      if (!p_pass_q) begin
        if (sh > SAT_HI) begin
          res_d.cal[i] = mic_pkg::AXIS_MAX;
          clip = 1'b1;
        end else if (sh < SAT_LO) begin
          res_d.cal[i] = mic_pkg::AXIS_MIN;
          clip = 1'b1;
        end else begin
          res_d.cal[i] = sh[mic_pkg::AXIS_W-1:0];
        end
      end
    end
    res_d.used_held = !p_ok_q;
    res_d.saturated = clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (r_ready) begin
      r_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_ready && p_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = r_valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/mic_checker.sv */
// Port-level checks of the magnetometer correction core and their bind.
`include "magnetometer_iron_correction_core_macros.svh"

module mic_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           cfg_ready_i,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input mic_pkg::axis_t cal_x_i,
  input mic_pkg::axis_t cal_y_i,
  input mic_pkg::axis_t cal_z_i,
  input logic           used_held_i,
  input logic           saturated_i
);

  logic                          in_fire;
  logic [3*mic_pkg::AXIS_W+1:0]  out_beat;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_beat = {cal_x_i, cal_y_i, cal_z_i, used_held_i, saturated_i};

  // config port never stalls
  `MIC_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_ready_i)

  // input back-pressure only when the result is full and stalled
  `MIC_ASSERT(a_stall_only_full, clk_i, rst_ni, !in_ready_i |-> out_valid_i && !out_ready_i)

  // an accepted beat reaches the output through the stage registers when the sink keeps draining
  `MIC_ASSERT(a_latency, clk_i, rst_ni, in_fire ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)

  // hold a stalled result
  `MIC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_beat))

endmodule

bind magnetometer_iron_correction_core mic_checker u_mic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_ready_i (cfg_i.ready),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .cal_x_i     (result_o.cal_x),
  .cal_y_i     (result_o.cal_y),
  .cal_z_i     (result_o.cal_z),
  .used_held_i (result_o.used_held),
  .saturated_i (result_o.saturated)
);
